@@ sv/ps2kc_pkg.sv @@
// Shared types, codes and scancode lookup tables for the PS/2 scancode decoder.
// No dependencies; every other file refers to this package by scoped names.
package ps2kc_pkg;

	// Result kinds
	localparam logic [1:0] KIND_KEY     = 2'd0;
	localparam logic [1:0] KIND_LED     = 2'd1;
	localparam logic [1:0] KIND_UNKNOWN = 2'd2;

	// Scancode set selections
	localparam logic [1:0] SET_1     = 2'd1;
	localparam logic [1:0] SET_2     = 2'd2;
	localparam logic [1:0] SET_RESET = 2'd2;

	// Prefix bytes
	localparam logic [7:0] PFX_EXT   = 8'he0;
	localparam logic [7:0] PFX_BREAK = 8'hf0;

	// HID usages that get special handling
	localparam logic [7:0] KC_NONE   = 8'h00;
	localparam logic [7:0] KC_LCTRL  = 8'he0;
	localparam logic [7:0] KC_LSHIFT = 8'he1;
	localparam logic [7:0] KC_LALT   = 8'he2;
	localparam logic [7:0] KC_RCTRL  = 8'he4;
	localparam logic [7:0] KC_RSHIFT = 8'he5;
	localparam logic [7:0] KC_RALT   = 8'he6;
	localparam logic [7:0] KC_CAPS   = 8'h39;
	localparam logic [7:0] KC_NUM    = 8'h53;
	localparam logic [7:0] KC_SCROLL = 8'h47;

	// Modifier status bits
	localparam logic [8:0] MOD_LSHIFT = 9'h001;
	localparam logic [8:0] MOD_RSHIFT = 9'h002;
	localparam logic [8:0] MOD_LCTRL  = 9'h004;
	localparam logic [8:0] MOD_RCTRL  = 9'h008;
	localparam logic [8:0] MOD_LALT   = 9'h010;
	localparam logic [8:0] MOD_RALT   = 9'h020;
	localparam logic [8:0] MOD_CAPS   = 9'h040;
	localparam logic [8:0] MOD_NUM    = 9'h080;
	localparam logic [8:0] MOD_SCROLL = 9'h100;

	// LED bits
	localparam logic [2:0] LED_SCROLL = 3'h1;
	localparam logic [2:0] LED_NUM    = 3'h2;
	localparam logic [2:0] LED_CAPS   = 3'h4;

	// Decode result handed from the core to the output register
	typedef struct packed {
		logic       hit;
		logic [1:0] kind;
		logic [7:0] key_code;
		logic [8:0] mods;
		logic [2:0] leds;
	} ps2kc_res_t;

	// Modifier bit for a usage, zero for anything that is not a modifier
	function automatic logic [8:0] mod_mask(input logic [7:0] key);
		logic [8:0] m;
		unique case (key)
			KC_LSHIFT: m = MOD_LSHIFT;
			KC_RSHIFT: m = MOD_RSHIFT;
			KC_LCTRL:  m = MOD_LCTRL;
			KC_RCTRL:  m = MOD_RCTRL;
			KC_LALT:   m = MOD_LALT;
			KC_RALT:   m = MOD_RALT;
			default:   m = '0;
		endcase
		return m;
	endfunction

	// Set 1 base table, indexed by the low seven bits
	function automatic logic [7:0] s1_base(input logic [6:0] c);
		logic [7:0] k;
		unique case (c)
			7'h01: k = 8'h29; 7'h02: k = 8'h1e; 7'h03: k = 8'h1f; 7'h04: k = 8'h20;
			7'h05: k = 8'h21; 7'h06: k = 8'h22; 7'h07: k = 8'h23; 7'h08: k = 8'h24;
			7'h09: k = 8'h25; 7'h0a: k = 8'h26; 7'h0b: k = 8'h27; 7'h0c: k = 8'h2d;
			7'h0d: k = 8'h2e; 7'h0e: k = 8'h2a; 7'h0f: k = 8'h2b;
			7'h10: k = 8'h14; 7'h11: k = 8'h1a; 7'h12: k = 8'h08; 7'h13: k = 8'h15;
			7'h14: k = 8'h17; 7'h15: k = 8'h1c; 7'h16: k = 8'h18; 7'h17: k = 8'h0c;
			7'h18: k = 8'h12; 7'h19: k = 8'h13; 7'h1a: k = 8'h2f; 7'h1b: k = 8'h30;
			7'h1c: k = 8'h28; 7'h1d: k = 8'he0; 7'h1e: k = 8'h04; 7'h1f: k = 8'h16;
			7'h20: k = 8'h07; 7'h21: k = 8'h09; 7'h22: k = 8'h0a; 7'h23: k = 8'h0b;
			7'h24: k = 8'h0d; 7'h25: k = 8'h0e; 7'h26: k = 8'h0f; 7'h27: k = 8'h33;
			7'h28: k = 8'h34; 7'h29: k = 8'h35; 7'h2a: k = 8'he1; 7'h2b: k = 8'h32;
			7'h2c: k = 8'h1d; 7'h2d: k = 8'h1b; 7'h2e: k = 8'h06; 7'h2f: k = 8'h19;
			7'h30: k = 8'h05; 7'h31: k = 8'h11; 7'h32: k = 8'h10; 7'h33: k = 8'h36;
			7'h34: k = 8'h37; 7'h35: k = 8'h38; 7'h36: k = 8'he5; 7'h37: k = 8'h55;
			7'h38: k = 8'he2; 7'h39: k = 8'h2c; 7'h3a: k = 8'h39; 7'h3b: k = 8'h3a;
			7'h3c: k = 8'h3b; 7'h3d: k = 8'h3c; 7'h3e: k = 8'h3d; 7'h3f: k = 8'h3e;
			7'h40: k = 8'h3f; 7'h41: k = 8'h40; 7'h42: k = 8'h41; 7'h43: k = 8'h42;
			7'h44: k = 8'h43; 7'h45: k = 8'h53; 7'h46: k = 8'h47; 7'h47: k = 8'h5f;
			7'h48: k = 8'h60; 7'h49: k = 8'h61; 7'h4a: k = 8'h56; 7'h4b: k = 8'h5c;
			7'h4c: k = 8'h5d; 7'h4d: k = 8'h5e; 7'h4e: k = 8'h57; 7'h4f: k = 8'h59;
			7'h50: k = 8'h5a; 7'h51: k = 8'h5b; 7'h52: k = 8'h62; 7'h53: k = 8'h63;
			7'h56: k = 8'h64; 7'h57: k = 8'h44; 7'h58: k = 8'h45;
			7'h65: k = 8'h52; 7'h66: k = 8'h51; 7'h67: k = 8'h50; 7'h68: k = 8'h4f;
			default: k = KC_NONE;
		endcase
		return k;
	endfunction

	// Set 1 extended table, looked up by the low seven bits
	function automatic logic [7:0] s1_ext(input logic [6:0] c);
		logic [7:0] k;
		unique case (c)
			7'h1c: k = 8'h58; 7'h1d: k = 8'he4; 7'h35: k = 8'h54; 7'h38: k = 8'he6;
			7'h47: k = 8'h4a; 7'h48: k = 8'h52; 7'h49: k = 8'h4b; 7'h4b: k = 8'h50;
			7'h4d: k = 8'h4f; 7'h4f: k = 8'h4d; 7'h50: k = 8'h51; 7'h51: k = 8'h4e;
			7'h52: k = 8'h49; 7'h53: k = 8'h4c;
			default: k = KC_NONE;
		endcase
		return k;
	endfunction

	// Set 2 base table, indexed by the full byte
	function automatic logic [7:0] s2_base(input logic [7:0] c);
		logic [7:0] k;
		unique case (c)
			8'h01: k = 8'h42; 8'h03: k = 8'h3e; 8'h04: k = 8'h3c; 8'h05: k = 8'h3a;
			8'h06: k = 8'h3b; 8'h07: k = 8'h45; 8'h09: k = 8'h43; 8'h0a: k = 8'h41;
			8'h0b: k = 8'h3f; 8'h0c: k = 8'h3d; 8'h0d: k = 8'h2b; 8'h0e: k = 8'h35;
			8'h11: k = 8'he2; 8'h12: k = 8'he1; 8'h14: k = 8'he0; 8'h15: k = 8'h14;
			8'h16: k = 8'h1e; 8'h1a: k = 8'h1d; 8'h1b: k = 8'h16; 8'h1c: k = 8'h04;
			8'h1d: k = 8'h1a; 8'h1e: k = 8'h1f;
			8'h21: k = 8'h06; 8'h22: k = 8'h1b; 8'h23: k = 8'h07; 8'h24: k = 8'h08;
			8'h25: k = 8'h21; 8'h26: k = 8'h20; 8'h29: k = 8'h2c; 8'h2a: k = 8'h19;
			8'h2b: k = 8'h09; 8'h2c: k = 8'h17; 8'h2d: k = 8'h15; 8'h2e: k = 8'h22;
			8'h31: k = 8'h11; 8'h32: k = 8'h05; 8'h33: k = 8'h0b; 8'h34: k = 8'h0a;
			8'h35: k = 8'h1c; 8'h36: k = 8'h23; 8'h3a: k = 8'h10; 8'h3b: k = 8'h0d;
			8'h3c: k = 8'h18; 8'h3d: k = 8'h24; 8'h3e: k = 8'h25;
			8'h41: k = 8'h37; 8'h42: k = 8'h0e; 8'h43: k = 8'h0c; 8'h44: k = 8'h12;
			8'h45: k = 8'h27; 8'h46: k = 8'h26; 8'h49: k = 8'h36; 8'h4a: k = 8'h38;
			8'h4b: k = 8'h0f; 8'h4c: k = 8'h33; 8'h4d: k = 8'h13; 8'h4e: k = 8'h2d;
			8'h52: k = 8'h34; 8'h54: k = 8'h2f; 8'h55: k = 8'h2e; 8'h58: k = 8'h39;
			8'h59: k = 8'he5; 8'h5a: k = 8'h28; 8'h5b: k = 8'h30; 8'h5d: k = 8'h32;
			8'h61: k = 8'h64; 8'h66: k = 8'h2a; 8'h69: k = 8'h59; 8'h6b: k = 8'h5c;
			8'h6c: k = 8'h5f;
			8'h70: k = 8'h62; 8'h71: k = 8'h63; 8'h72: k = 8'h5a; 8'h73: k = 8'h5d;
			8'h74: k = 8'h5e; 8'h75: k = 8'h60; 8'h76: k = 8'h29; 8'h77: k = 8'h53;
			8'h78: k = 8'h44; 8'h79: k = 8'h57; 8'h7a: k = 8'h5b; 8'h7b: k = 8'h56;
			8'h7c: k = 8'h55; 8'h7d: k = 8'h61; 8'h7e: k = 8'h47; 8'h83: k = 8'h40;
			default: k = KC_NONE;
		endcase
		return k;
	endfunction

	// Set 2 extended table, looked up by the full byte
	function automatic logic [7:0] s2_ext(input logic [7:0] c);
		logic [7:0] k;
		unique case (c)
			8'h11: k = 8'he6; 8'h14: k = 8'he4; 8'h4a: k = 8'h54; 8'h5a: k = 8'h58;
			8'h69: k = 8'h4d; 8'h6b: k = 8'h50; 8'h6c: k = 8'h4a; 8'h70: k = 8'h49;
			8'h71: k = 8'h4c; 8'h72: k = 8'h51; 8'h74: k = 8'h4f; 8'h75: k = 8'h52;
			8'h7a: k = 8'h4e; 8'h7d: k = 8'h4b;
			default: k = KC_NONE;
		endcase
		return k;
	endfunction

endpackage

@@ sv/ps2kc_lookup.sv @@
// Scancode to HID usage lookup: picks the base or extended table of the active set.
// Depends on ps2kc_pkg for the tables and set codes.
module ps2kc_lookup (
	input  logic [7:0] code,
	input  logic       ext,
	input  logic [1:0] scancode_set,
	output logic [7:0] key
);

	// Select the table; set 1 uses only the low seven bits
	always_comb begin
		if (scancode_set == ps2kc_pkg::SET_1) begin
			key = ext ? ps2kc_pkg::s1_ext(code[6:0]) : ps2kc_pkg::s1_base(code[6:0]);
		end else begin
			key = ext ? ps2kc_pkg::s2_ext(code) : ps2kc_pkg::s2_base(code);
		end
	end

endmodule

@@ sv/ps2kc_core.sv @@
// Decode core: prefix flags, modifier and lock state, and the result of one byte.
// Depends on ps2kc_pkg and ps2kc_lookup.
module ps2kc_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [7:0]             code,
	input  logic [1:0]             scancode_set,
	output ps2kc_pkg::ps2kc_res_t  res
);

	logic       ext_q, ext_d;
	logic       brk_q, brk_d;
	logic [8:0] mods_q, mods_d;
	logic [2:0] leds_q, leds_d;
	logic [7:0] key;
	logic [8:0] mbit;

	ps2kc_lookup u_lookup (
		.code         (code),
		.ext          (ext_q),
		.scancode_set (scancode_set),
		.key          (key)
	);

	assign mbit = ps2kc_pkg::mod_mask(key);

	// Work out next state and the result for the byte in the input register
	always_comb begin
		logic brk;
		logic known;
		ext_d    = ext_q;
		brk_d    = brk_q;
		mods_d   = mods_q;
		leds_d   = leds_q;
		brk      = 1'b0;
		known    = 1'b0;
		res.hit  = 1'b0;
		res.kind = ps2kc_pkg::KIND_KEY;
		res.key_code = ps2kc_pkg::KC_NONE;
		if (code == ps2kc_pkg::PFX_EXT) begin
			ext_d = 1'b1;
		end else if (scancode_set == ps2kc_pkg::SET_2 && code == ps2kc_pkg::PFX_BREAK) begin
			// extension flag survives a break prefix
			brk_d = 1'b1;
		end else begin
			ext_d = 1'b0;
			if (scancode_set == ps2kc_pkg::SET_1) begin
				brk   = code[7];
				known = 1'b1;
			end else if (scancode_set == ps2kc_pkg::SET_2) begin
				brk   = brk_q;
				brk_d = 1'b0;
				known = 1'b1;
			end
			if (known) begin
				if (key == ps2kc_pkg::KC_NONE) begin
					res.hit  = 1'b1;
					res.kind = ps2kc_pkg::KIND_UNKNOWN;
				end else if (mbit != '0) begin
					// modifier: set on make, clear on break, no beat
					mods_d = brk ? (mods_q & ~mbit) : (mods_q | mbit);
				end else if (!brk) begin
					res.hit = 1'b1;
					priority if (key == ps2kc_pkg::KC_CAPS) begin
						mods_d   = mods_q ^ ps2kc_pkg::MOD_CAPS;
						leds_d   = leds_q ^ ps2kc_pkg::LED_CAPS;
						res.kind = ps2kc_pkg::KIND_LED;
					end else if (key == ps2kc_pkg::KC_NUM) begin
						mods_d   = mods_q ^ ps2kc_pkg::MOD_NUM;
						leds_d   = leds_q ^ ps2kc_pkg::LED_NUM;
						res.kind = ps2kc_pkg::KIND_LED;
					end else if (key == ps2kc_pkg::KC_SCROLL) begin
						mods_d   = mods_q ^ ps2kc_pkg::MOD_SCROLL;
						leds_d   = leds_q ^ ps2kc_pkg::LED_SCROLL;
						res.kind = ps2kc_pkg::KIND_LED;
					end else begin
						res.kind     = ps2kc_pkg::KIND_KEY;
						res.key_code = key;
					end
				end
			end
		end
		res.mods = mods_d;
		res.leds = leds_d;
	end

	// Commit state when the byte moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q  <= 1'b0;
			brk_q  <= 1'b0;
			mods_q <= '0;
			leds_q <= '0;
		end else if (advance) begin
			ext_q  <= ext_d;
			brk_q  <= brk_d;
			mods_q <= mods_d;
			leds_q <= leds_d;
		end
	end

	// Lock LEDs always mirror the lock bits of the modifier status
	a_leds_track_locks: assert property (@(posedge clk) disable iff (!arst_n)
		leds_q == {mods_q[6], mods_q[7], mods_q[8]})
		else $error("LED state out of step with lock bits");

	// A byte that is not a prefix always clears the extension flag
	a_ext_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && code != ps2kc_pkg::PFX_EXT
		&& !(scancode_set == ps2kc_pkg::SET_2 && code == ps2kc_pkg::PFX_BREAK) |=> !ext_q)
		else $error("extension flag kept past a plain byte");

endmodule

@@ sv/ps2_scancode_to_keycode_decoder.sv @@
// Top level of the PS/2 scancode decoder: input register, decode core, result register.
// Depends on ps2kc_pkg and ps2kc_core.
//
//  Port group     Dir  Handshake           Payload
//  scan byte      in   in_valid/in_ready   scan_byte
//  result         out  out_valid/out_ready kind, key_code, modifier_status, led_bits, raw_code
//  config         in   cfg_we (no wait)    cfg_wdata (scancode set)
//
// One byte per cycle while the result side is not stalled; a byte is held in the input register,
// and its result shows on the outputs once it is loaded into the result register after the lookup.
// Reset clears the prefix flags, modifiers and LEDs and selects scancode set 2.
// A stalled result holds in the result register; the input register still takes
// a byte, and in_ready drops only while both registers are full and out_ready is low.
module ps2_scancode_to_keycode_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] key_code,
	output logic [8:0] modifier_status,
	output logic [2:0] led_bits,
	output logic [7:0] raw_code
);

	logic [1:0]            scancode_set_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  valid_s2;
	logic                  advance;
	ps2kc_pkg::ps2kc_res_t res;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scancode_set_q <= ps2kc_pkg::SET_RESET;
		end else if (cfg_we) begin
			scancode_set_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= scan_byte;
		end
	end

	ps2kc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.code         (byte_s1),
		.scancode_set (scancode_set_q),
		.res          (res)
	);

	// Result register: load on advance, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.hit;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.hit) begin
			kind            <= res.kind;
			key_code        <= res.key_code;
			modifier_status <= res.mods;
			led_bits        <= res.leds;
			raw_code        <= byte_s1;
		end
	end

	assign out_valid = valid_s2;

	// Result kind is one of the three defined codes
	a_kind_defined: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == ps2kc_pkg::KIND_KEY || kind == ps2kc_pkg::KIND_LED
		|| kind == ps2kc_pkg::KIND_UNKNOWN))
		else $error("undefined result kind");

	// Key beats carry a usage, other beats carry none
	a_key_code_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((kind == ps2kc_pkg::KIND_KEY) == (key_code != ps2kc_pkg::KC_NONE)))
		else $error("key code does not match result kind");

	// A waiting result is never overwritten by the core
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !advance)
		else $error("core advanced over a stalled result");

	// A config write takes effect on the next cycle
	a_cfg_applied: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> scancode_set_q == $past(cfg_wdata))
		else $error("scancode set not updated by write");

endmodule

@@ tb/sv/ps2_scancode_to_keycode_decoder_test.sv @@
// Self-checking test of the PS/2 scancode decoder in scancode sets 1 and 2 and the unused sets.
// Holds its own decoder model; depends on ps2kc_pkg and ps2_scancode_to_keycode_decoder.
// Directed key sequences first, then random traffic with random idling on both channels.
module ps2_scancode_to_keycode_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] SET_UNUSED_0 = 2'd0;
	localparam logic [1:0] SET_UNUSED_3 = 2'd3;
	localparam logic [7:0] SET1_BREAK_BIT = 8'h80;
	localparam int S1_BASE_LAST = 104;
	localparam int S2_BASE_LAST = 131;
	localparam int EXT_ENTRIES = 14;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_LIMIT = 3000;
	localparam int MAX_REPORTS = 10;

	// Set 1 base usages by low seven bits; anything past the end is unmapped
	localparam logic [0:S1_BASE_LAST][7:0] S1_BASE = {
		128'h00291e1f20212223_242526272d2e2a2b,
		128'h141a0815171c180c_12132f3028e00416,
		128'h07090a0b0d0e0f33_3435e1321d1b0619,
		128'h051110363738e555_e22c393a3b3c3d3e,
		128'h3f4041424353475f_6061565c5d5e5759,
		128'h5a5b626300006444_4500000000000000,
		72'h00000000_00525150_4f
	};

	// Set 2 base usages by full byte; anything past the end is unmapped
	localparam logic [0:S2_BASE_LAST][7:0] S2_BASE = {
		128'h0042003e3c3a3b45_0043413f3d2b3500,
		128'h00e2e100e0141e00_00001d16041a1f00,
		128'h00061b0708212000_002c190917152200,
		128'h0011050b0a1c2300_0000100d18242500,
		128'h00370e0c12272600_0036380f33132d00,
		128'h000034002f2e0000_39e5283000320000,
		128'h0064000000002a00_0059005c5f000000,
		128'h62635a5d5e602953_44575b5655614700,
		32'h00000040
	};

	// Extended codes as {code, usage} pairs
	localparam logic [0:EXT_ENTRIES-1][15:0] S1_EXT = {
		16'h1c58, 16'h1de4, 16'h3554, 16'h38e6, 16'h474a, 16'h4852, 16'h494b,
		16'h4b50, 16'h4d4f, 16'h4f4d, 16'h5051, 16'h514e, 16'h5249, 16'h534c
	};
	localparam logic [0:EXT_ENTRIES-1][15:0] S2_EXT = {
		16'h11e6, 16'h14e4, 16'h4a54, 16'h5a58, 16'h694d, 16'h6b50, 16'h6c4a,
		16'h7049, 16'h714c, 16'h7251, 16'h744f, 16'h7552, 16'h7a4e, 16'h7d4b
	};

	// Scancode set per random phase
	localparam int PHASES = 12;
	localparam logic [0:PHASES-1][1:0] PHASE_SETS = {
		ps2kc_pkg::SET_2, ps2kc_pkg::SET_1, ps2kc_pkg::SET_2, SET_UNUSED_3,
		ps2kc_pkg::SET_1, ps2kc_pkg::SET_2, SET_UNUSED_0, ps2kc_pkg::SET_1,
		ps2kc_pkg::SET_2, ps2kc_pkg::SET_1, ps2kc_pkg::SET_2, ps2kc_pkg::SET_1
	};

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] key_code;
		logic [8:0] mods;
		logic [2:0] leds;
		logic [7:0] raw;
	} keyrep_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] scan_byte;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] kind;
	logic [7:0] key_code;
	logic [8:0] modifier_status;
	logic [2:0] led_bits;
	logic [7:0] raw_code;

	ps2_scancode_to_keycode_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.scan_byte(scan_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.key_code(key_code),
		.modifier_status(modifier_status),
		.led_bits(led_bits),
		.raw_code(raw_code)
	);

	// Decoder model state, reset values
	logic [1:0] active_set = ps2kc_pkg::SET_RESET;
	logic       ext_pend = 1'b0;
	logic       brk_pend = 1'b0;
	logic [8:0] mods_now = '0;
	logic [2:0] leds_now = '0;
	keyrep_t    expected_keys[$];

	// Stimulus side bookkeeping
	logic [1:0] stim_set = ps2kc_pkg::SET_RESET;
	int         burst_left = 0;
	int         bytes_sent = 0;
	int         fail_count = 0;
	int         idle_cycles = 0;
	keyrep_t    got_key;
	keyrep_t    want_key;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Decode one accepted byte and queue the result it causes, if any
	function automatic void decode_scan_byte(input logic [7:0] b);
		logic       ext;
		logic       brk;
		logic [7:0] key;
		logic [8:0] mbit;
		int         i;
		if (b == ps2kc_pkg::PFX_EXT) begin
			ext_pend = 1'b1;
			return;
		end
		if (active_set == ps2kc_pkg::SET_2 && b == ps2kc_pkg::PFX_BREAK) begin
			brk_pend = 1'b1;
			return;
		end
		ext = ext_pend;
		ext_pend = 1'b0;
		key = ps2kc_pkg::KC_NONE;
		if (active_set == ps2kc_pkg::SET_1) begin
			brk = b[7];
			if (ext) begin
				for (i = 0; i < EXT_ENTRIES; i++)
					if (S1_EXT[i][15:8] == {1'b0, b[6:0]})
						key = S1_EXT[i][7:0];
			end else if (int'(b[6:0]) <= S1_BASE_LAST) begin
				key = S1_BASE[b[6:0]];
			end
		end else if (active_set == ps2kc_pkg::SET_2) begin
			brk = brk_pend;
			brk_pend = 1'b0;
			if (ext) begin
				for (i = 0; i < EXT_ENTRIES; i++)
					if (S2_EXT[i][15:8] == b)
						key = S2_EXT[i][7:0];
			end else if (int'(b) <= S2_BASE_LAST) begin
				key = S2_BASE[b];
			end
		end else begin
			return;
		end
		if (key == ps2kc_pkg::KC_NONE) begin
			expected_keys.push_back(keyrep_t'{ps2kc_pkg::KIND_UNKNOWN, ps2kc_pkg::KC_NONE,
				mods_now, leds_now, b});
			return;
		end
		case (key)
			ps2kc_pkg::KC_LSHIFT: mbit = ps2kc_pkg::MOD_LSHIFT;
			ps2kc_pkg::KC_RSHIFT: mbit = ps2kc_pkg::MOD_RSHIFT;
			ps2kc_pkg::KC_LCTRL:  mbit = ps2kc_pkg::MOD_LCTRL;
			ps2kc_pkg::KC_RCTRL:  mbit = ps2kc_pkg::MOD_RCTRL;
			ps2kc_pkg::KC_LALT:   mbit = ps2kc_pkg::MOD_LALT;
			ps2kc_pkg::KC_RALT:   mbit = ps2kc_pkg::MOD_RALT;
			default:              mbit = '0;
		endcase
		if (mbit != '0) begin
			mods_now = brk ? (mods_now & ~mbit) : (mods_now | mbit);
			return;
		end
		if (brk)
			return;
		case (key)
			ps2kc_pkg::KC_CAPS: begin
				mods_now ^= ps2kc_pkg::MOD_CAPS;
				leds_now ^= ps2kc_pkg::LED_CAPS;
			end
			ps2kc_pkg::KC_NUM: begin
				mods_now ^= ps2kc_pkg::MOD_NUM;
				leds_now ^= ps2kc_pkg::LED_NUM;
			end
			ps2kc_pkg::KC_SCROLL: begin
				mods_now ^= ps2kc_pkg::MOD_SCROLL;
				leds_now ^= ps2kc_pkg::LED_SCROLL;
			end
			default: begin
				expected_keys.push_back(keyrep_t'{ps2kc_pkg::KIND_KEY, key,
					mods_now, leds_now, b});
				return;
			end
		endcase
		expected_keys.push_back(keyrep_t'{ps2kc_pkg::KIND_LED, ps2kc_pkg::KC_NONE,
			mods_now, leds_now, b});
	endfunction

	// Track config writes, predict accepted bytes, check result beats, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				active_set = cfg_wdata;
			if (out_valid && out_ready) begin
				got_key = '{kind, key_code, modifier_status, led_bits, raw_code};
				if (expected_keys.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected result: kind %0d key %h mods %h leds %h raw %h",
							kind, key_code, modifier_status, led_bits, raw_code);
				end else begin
					want_key = expected_keys.pop_front();
					if (got_key !== want_key) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display({"mismatch: exp kind %0d key %h mods %h leds %h raw %h,",
								" got kind %0d key %h mods %h leds %h raw %h"},
								want_key.kind, want_key.key_code, want_key.mods,
								want_key.leds, want_key.raw, kind, key_code,
								modifier_status, led_bits, raw_code);
					end
				end
			end
			if (in_valid && in_ready)
				decode_scan_byte(scan_byte);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Result side: switch between stall patterns every so often
	initial begin
		int  cyc;
		int  rx_mode;
		int  hold;
		bit  hold_val;
		cyc = 0;
		rx_mode = 0;
		hold = 0;
		hold_val = 1'b1;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 97 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (cyc % 4 == 0);
				default: begin
					if (hold == 0) begin
						hold = $urandom_range(1, 30);
						hold_val = ~hold_val;
					end
					hold--;
					out_ready <= hold_val;
				end
			endcase
		end
	end

	// Present one byte and hold it until accepted; idle between bursts
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		scan_byte <= b;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		bytes_sent++;
	endtask

	// Send one key event with the prefixes of the current set
	task automatic send_key(input bit ext, input bit brk, input logic [7:0] code);
		if (ext)
			send_byte(ps2kc_pkg::PFX_EXT);
		if (stim_set == ps2kc_pkg::SET_1) begin
			send_byte(brk ? (code | SET1_BREAK_BIT) : code);
		end else begin
			if (brk)
				send_byte(ps2kc_pkg::PFX_BREAK);
			send_byte(code);
		end
	endtask

	// Drop valid, wait for every expected result, then let the pipe settle
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_keys.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic select_set(input logic [1:0] set_sel);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= set_sel;
		@(posedge clk);
		cfg_we <= 1'b0;
		stim_set = set_sel;
	endtask

	// Set 2 from reset: modifiers, extended keys, locks, table ends, unmapped codes
	task automatic test_set2_directed();
		send_key(1'b0, 1'b0, 8'h1c);
		send_key(1'b0, 1'b0, 8'h12);
		send_key(1'b0, 1'b0, 8'h1c);
		send_key(1'b0, 1'b1, 8'h12);
		send_key(1'b1, 1'b0, 8'h11);
		send_key(1'b1, 1'b0, 8'h75);
		send_key(1'b1, 1'b1, 8'h11);
		send_key(1'b0, 1'b0, 8'h58);
		send_key(1'b0, 1'b1, 8'h58);
		send_key(1'b0, 1'b0, 8'h77);
		send_key(1'b0, 1'b0, 8'h7e);
		send_key(1'b0, 1'b0, 8'h83);
		send_key(1'b0, 1'b0, 8'h00);
		send_byte(8'hff);
		send_key(1'b0, 1'b1, 8'h00);
		send_key(1'b1, 1'b0, 8'h1c);
		send_byte(ps2kc_pkg::PFX_EXT);
		send_key(1'b1, 1'b0, 8'h5a);
	endtask

	// Set 1: bit 7 breaks, extended by low bits, page up/down, unmapped codes
	task automatic test_set1_directed();
		select_set(ps2kc_pkg::SET_1);
		send_key(1'b0, 1'b0, 8'h1e);
		send_key(1'b0, 1'b0, 8'h2a);
		send_key(1'b0, 1'b1, 8'h2a);
		send_key(1'b1, 1'b0, 8'h49);
		send_key(1'b1, 1'b0, 8'h51);
		send_key(1'b1, 1'b0, 8'h1d);
		send_key(1'b0, 1'b0, 8'h10);
		send_key(1'b1, 1'b1, 8'h1d);
		send_key(1'b0, 1'b0, 8'h3a);
		send_key(1'b0, 1'b0, 8'h45);
		send_key(1'b0, 1'b0, 8'h46);
		send_key(1'b0, 1'b1, 8'h46);
		send_key(1'b0, 1'b0, 8'h00);
		send_byte(8'hff);
		send_byte(SET1_BREAK_BIT);
		send_byte(ps2kc_pkg::PFX_BREAK);
		send_key(1'b1, 1'b0, 8'h7f);
	endtask

	// Sets 0 and 3 decode no keys; an extension left pending carries over a set change
	task automatic test_unused_sets();
		select_set(SET_UNUSED_0);
		send_byte(ps2kc_pkg::PFX_EXT);
		send_byte(8'h1c);
		send_byte(ps2kc_pkg::PFX_BREAK);
		select_set(SET_UNUSED_3);
		send_byte(8'hff);
		send_byte(ps2kc_pkg::PFX_EXT);
		select_set(ps2kc_pkg::SET_2);
		send_byte(8'h5a);
	endtask

	// Mostly well-formed key events with random content, some noise
	task automatic random_key_event();
		int         r;
		bit         ext;
		logic [7:0] code;
		r = $urandom_range(0, 99);
		ext = 1'($urandom_range(0, 1));
		if (r < 12) begin
			send_byte(8'($urandom_range(0, 255)));
		end else if (r < 24) begin
			if (stim_set == ps2kc_pkg::SET_1)
				case ($urandom_range(0, 3))
					0: code = 8'h2a;
					1: code = 8'h36;
					2: code = 8'h1d;
					default: code = 8'h38;
				endcase
			else
				case ($urandom_range(0, 3))
					0: code = 8'h12;
					1: code = 8'h59;
					2: code = 8'h14;
					default: code = 8'h11;
				endcase
			send_key(ext, 1'($urandom_range(0, 1)), code);
		end else if (r < 30) begin
			if (stim_set == ps2kc_pkg::SET_1)
				case ($urandom_range(0, 2))
					0: code = 8'h3a;
					1: code = 8'h45;
					default: code = 8'h46;
				endcase
			else
				case ($urandom_range(0, 2))
					0: code = 8'h58;
					1: code = 8'h77;
					default: code = 8'h7e;
				endcase
			send_key(1'b0, $urandom_range(0, 3) == 0, code);
		end else if (r < 50) begin
			code = (stim_set == ps2kc_pkg::SET_1)
				? S1_EXT[$urandom_range(0, EXT_ENTRIES - 1)][15:8]
				: S2_EXT[$urandom_range(0, EXT_ENTRIES - 1)][15:8];
			send_key(1'b1, $urandom_range(0, 2) == 0, code);
		end else begin
			code = (stim_set == ps2kc_pkg::SET_1) ? 8'($urandom_range(0, S1_BASE_LAST))
				: 8'($urandom_range(0, S2_BASE_LAST));
			send_key(1'b0, $urandom_range(0, 3) == 0, code);
		end
	endtask

	// Random phases across all set values, with an occasional full drain mid-phase
	task automatic test_random_traffic();
		int p;
		int target;
		for (p = 0; p < PHASES; p++) begin
			select_set(PHASE_SETS[p]);
			target = bytes_sent;
			if (PHASE_SETS[p] == ps2kc_pkg::SET_1 || PHASE_SETS[p] == ps2kc_pkg::SET_2) begin
				target += 180;
				while (bytes_sent < target) begin
					random_key_event();
					if ($urandom_range(0, 299) == 0)
						drain_results();
				end
			end else begin
				target += 30;
				while (bytes_sent < target)
					send_byte(($urandom_range(0, 4) == 0) ? ps2kc_pkg::PFX_EXT
						: 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = ps2kc_pkg::SET_RESET;
		in_valid = 1'b0;
		scan_byte = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_set2_directed();
		test_set1_directed();
		test_unused_sets();
		test_random_traffic();
		drain_results();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
